// ===== hw/rtl/glq_pkg.sv =====
// Shared types and constants of the glyph quad layout block.
package glq_pkg;

  // Request kinds.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_DRAW = 1'b1;

  // Quad corners in emission order.
  localparam logic [1:0] CORNER_BR = 2'd0;
  localparam logic [1:0] CORNER_TR = 2'd1;
  localparam logic [1:0] CORNER_TL = 2'd2;
  localparam logic [1:0] CORNER_BL = 2'd3;

  // Configuration port geometry and register indexes.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_W = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_H = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PEN_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PEN_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT    = 3'd6;

  // Configuration reset values.
  localparam logic [12:0] ATLAS_SIZE_RST = 13'd256;
  localparam logic [15:0] SCALE_RST      = 16'd256;
  localparam logic [31:0] COLOR_RST      = 32'hFFFF_FFFF;

  // Fraction bits of the scale register; positions carry 8 fraction bits.
  localparam int SCALE_FRAC_BITS = 8;

  // Texture coordinate divider: one quotient bit per step.
  localparam int DIV_STEPS = 16;

  // One request as it arrives on the input channel.
  typedef struct packed {
    logic              req_type;
    logic [7:0]        char_code;
    logic [11:0]       atlas_x;
    logic [11:0]       atlas_y;
    logic [7:0]        glyph_width;
    logic [7:0]        glyph_height;
    logic signed [7:0] x_offset;
    logic signed [7:0] y_offset;
    logic [7:0]        x_advance;
    logic              first_of_string;
  } glq_req_t;

  // One vertex as it leaves on the output channel.
  typedef struct packed {
    logic [1:0]         corner;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [31:0]        vertex_color;
    logic [7:0]         vertex_slot;
    logic               last_vertex;
  } glq_vtx_t;

  // One glyph table entry with its valid mark on top.
  typedef struct packed {
    logic              vld;
    logic [7:0]        adv;
    logic signed [7:0] yo;
    logic signed [7:0] xo;
    logic [7:0]        gh;
    logic [7:0]        gw;
    logic [11:0]       ay;
    logic [11:0]       ax;
  } glq_glyph_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic clr;    // clearing pass writes one table entry
    logic take;   // input request accepted this cycle
    logic miss;   // looked-up glyph missing: halt the string
    logic start;  // glyph found: set up operands, start dividers
    logic emit;   // load the next vertex into the output register
  } glq_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clr_last;   // clearing pass at its final entry
    logic draw_go;    // pending request is a draw that is not halted
    logic hit;        // looked-up entry is valid
    logic calc_done;  // positions and texture coordinates are ready
    logic out_free;   // output register can take a vertex
    logic last_vtx;   // next vertex to emit is the final corner
  } glq_sts_t;

endpackage

// ===== hw/rtl/glq_req_if.sv =====
// Input request channel of the glyph quad layout block.
interface glq_req_if;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [7:0]        char_code;
  logic [11:0]       atlas_x;
  logic [11:0]       atlas_y;
  logic [7:0]        glyph_width;
  logic [7:0]        glyph_height;
  logic signed [7:0] x_offset;
  logic signed [7:0] y_offset;
  logic [7:0]        x_advance;
  logic              first_of_string;

  modport source (
    output valid, req_type, char_code, atlas_x, atlas_y, glyph_width, glyph_height,
           x_offset, y_offset, x_advance, first_of_string,
    input  ready
  );

  modport sink (
    input  valid, req_type, char_code, atlas_x, atlas_y, glyph_width, glyph_height,
           x_offset, y_offset, x_advance, first_of_string,
    output ready
  );
endinterface

// ===== hw/rtl/glq_vtx_if.sv =====
// Output vertex channel of the glyph quad layout block.
interface glq_vtx_if;
  logic               valid;
  logic               ready;
  logic [1:0]         corner;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [15:0]        tex_u;
  logic [15:0]        tex_v;
  logic [31:0]        vertex_color;
  logic [7:0]         vertex_slot;
  logic               last_vertex;

  modport source (
    output valid, corner, pos_x, pos_y, tex_u, tex_v, vertex_color, vertex_slot,
           last_vertex,
    input  ready
  );

  modport sink (
    input  valid, corner, pos_x, pos_y, tex_u, tex_v, vertex_color, vertex_slot,
           last_vertex,
    output ready
  );
endinterface

// ===== hw/rtl/glq_div.sv =====
// Bit-serial rounded texture coordinate divider with saturation.
module glq_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [12:0] texel_i,
  input  logic [12:0] size_i,
  output logic        busy_o,
  output logic [15:0] quot_o
);
  import glq_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic [12:0]      dsr;
  logic [29:0]      dvd_full;
  logic [13:0]      dvd_hi;
  logic             sat;
  logic [13:0]      trial;
  logic             ge;
  logic [12:0]      div_q;
  logic [12:0]      rem_q, rem_d;
  logic [15:0]      low_q;
  logic             sat_q;
  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;

  // A zero atlas size counts as one; the dividend carries the rounding half.
  always_comb begin
    dsr      = (size_i == 13'd0) ? 13'd1 : size_i;
    dvd_full = {1'b0, texel_i, 16'h0000} + 30'(dsr[12:1]);
    dvd_hi   = dvd_full[29:16];
    // The quotient overflows 16 bits exactly when the upper part reaches the divisor.
    sat      = dvd_hi >= {1'b0, dsr};
  end

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem_q, low_q[15]};
    ge    = trial >= {1'b0, div_q};
    rem_d = ge ? 13'(trial - {1'b0, div_q}) : trial[12:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(DIV_STEPS - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Remainder and quotient shift register; quotient bits replace dividend bits.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= dsr;
      rem_q <= dvd_hi[12:0];
      low_q <= dvd_full[15:0];
      sat_q <= sat;
    end else if (busy_q) begin
      rem_q <= rem_d;
      low_q <= {low_q[14:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = sat_q ? 16'hFFFF : low_q;

endmodule

// ===== hw/rtl/glq_ctrl.sv =====
// Sequencing state machine of the glyph quad layout block.
module glq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  glq_pkg::glq_sts_t  sts_i,
  output glq_pkg::glq_cmd_t  cmd_o
);
  import glq_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_LOOKUP = 5'b00100,
    ST_CALC   = 5'b01000,
    ST_EMIT   = 5'b10000
  } glq_state_e;

  glq_state_e state_q, state_d;

  // Commands follow directly from the state, the input valid and the status flags.
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    cmd_o.clr   = (state_q == ST_CLEAR);
    cmd_o.take  = in_valid_i && in_ready_o;
    cmd_o.miss  = (state_q == ST_LOOKUP) && !sts_i.hit;
    cmd_o.start = (state_q == ST_LOOKUP) && sts_i.hit;
    cmd_o.emit  = (state_q == ST_EMIT) && sts_i.out_free;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_o.take && sts_i.draw_go) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_d = sts_i.hit ? ST_CALC : ST_IDLE;
      end
      ST_CALC: begin
        if (sts_i.calc_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd_o.emit && sts_i.last_vtx) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/glq_dpath.sv =====
// Datapath of the glyph quad layout block: glyph table, pen, scaling and dividers.
module glq_dpath #(
  parameter int NUM_GLYPHS = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  glq_pkg::glq_cmd_t                 cmd_i,
  output glq_pkg::glq_sts_t                 sts_o,
  input  glq_pkg::glq_req_t                 req_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output glq_pkg::glq_vtx_t                 vtx_o,
  input  logic                              cfg_we_i,
  input  logic [glq_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [glq_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import glq_pkg::*;

  localparam int IDX_W      = $clog2(NUM_GLYPHS);
  localparam int CODE_EXT_W = ((IDX_W > 8) ? IDX_W : 8) + 1;
  localparam int NUM_OPND   = 4;
  localparam int NUM_DIV    = 4;
  localparam int MCNT_W     = $clog2(NUM_OPND + 1);
  localparam int OPND_W     = 18;
  localparam int PROD_W     = OPND_W + 17;
  localparam int SW         = PROD_W + 9;
  localparam int RSH        = (SCALE_FRAC_BITS > 8) ? SCALE_FRAC_BITS - 8 : 0;
  localparam int LSH        = (SCALE_FRAC_BITS < 8) ? 8 - SCALE_FRAC_BITS : 0;
  localparam logic signed [SW-1:0] HALF = SW'((2 ** RSH) / 2);

  // Configuration registers.
  logic [12:0]        aw_q, ah_q;
  logic [15:0]        scale_q;
  logic signed [15:0] psx_q, psy_q;
  logic [31:0]        color_q;
  logic [7:0]         slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aw_q    <= ATLAS_SIZE_RST;
      ah_q    <= ATLAS_SIZE_RST;
      scale_q <= SCALE_RST;
      psx_q   <= '0;
      psy_q   <= '0;
      color_q <= COLOR_RST;
      slot_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ATLAS_W: aw_q    <= cfg_data_i[12:0];
        CFG_ATLAS_H: ah_q    <= cfg_data_i[12:0];
        CFG_SCALE:   scale_q <= cfg_data_i[15:0];
        CFG_PEN_X:   psx_q   <= cfg_data_i[15:0];
        CFG_PEN_Y:   psy_q   <= cfg_data_i[15:0];
        CFG_COLOR:   color_q <= cfg_data_i[31:0];
        CFG_SLOT:    slot_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Code decode: codes beyond the table are dropped on load and miss on draw.
  logic [CODE_EXT_W-1:0] code_ext;
  logic                  code_ok;
  logic [IDX_W-1:0]      idx;

  assign code_ext = CODE_EXT_W'(req_i.char_code);
  assign code_ok  = code_ext < CODE_EXT_W'(NUM_GLYPHS);
  assign idx      = code_ext[IDX_W-1:0];

  // Clearing pass after reset walks every table entry once.
  logic [IDX_W-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // Glyph table write port: clearing pass or a load request.
  glq_glyph_t       mem_q [NUM_GLYPHS];
  glq_glyph_t       mem_wdata;
  logic [IDX_W-1:0] mem_widx;
  logic             mem_we;
  glq_glyph_t       rd_q;
  logic             code_ok_q;
  logic             draw_take;

  assign draw_take = cmd_i.take && (req_i.req_type == REQ_DRAW);

  always_comb begin
    mem_wdata.vld = 1'b1;
    mem_wdata.adv = req_i.x_advance;
    mem_wdata.yo  = req_i.y_offset;
    mem_wdata.xo  = req_i.x_offset;
    mem_wdata.gh  = req_i.glyph_height;
    mem_wdata.gw  = req_i.glyph_width;
    mem_wdata.ay  = req_i.atlas_y;
    mem_wdata.ax  = req_i.atlas_x;
    mem_widx      = idx;
    mem_we        = cmd_i.take && (req_i.req_type == REQ_LOAD) && code_ok;
    if (cmd_i.clr) begin
      mem_wdata = '0;
      mem_widx  = clr_cnt_q;
      mem_we    = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_widx] <= mem_wdata;
    end
  end

  // Registered table read for a draw request.
  always_ff @(posedge clk_i) begin
    if (draw_take) begin
      rd_q      <= mem_q[idx];
      code_ok_q <= code_ok;
    end
  end

  // Pen and halt state.
  logic signed [15:0] pen_x_q;
  logic               halted_q;
  logic signed [16:0] pen_sum;
  logic signed [15:0] pen_next;

  always_comb begin
    pen_sum  = 17'(pen_x_q) + $signed({9'b0, rd_q.adv});
    pen_next = (!pen_sum[16] && pen_sum[15]) ? 16'sh7FFF : pen_sum[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q  <= '0;
      halted_q <= 1'b0;
    end else if (draw_take && req_i.first_of_string) begin
      pen_x_q  <= psx_q;
      halted_q <= 1'b0;
    end else if (cmd_i.miss) begin
      halted_q <= 1'b1;
    end else if (cmd_i.start) begin
      pen_x_q  <= pen_next;
    end
  end

  // Corner operands: right, left, bottom, top edges in pixels.
  logic signed [OPND_W-1:0] opnd_q [NUM_OPND];
  logic signed [OPND_W-1:0] left, top;

  always_comb begin
    left = OPND_W'(pen_x_q) + OPND_W'(rd_q.xo);
    top  = OPND_W'(psy_q) + OPND_W'(rd_q.yo);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      opnd_q[0] <= left + $signed({10'b0, rd_q.gw});
      opnd_q[1] <= left;
      opnd_q[2] <= top + $signed({10'b0, rd_q.gh});
      opnd_q[3] <= top;
    end
  end

  // Shared multiplier steps through the four operands, then rounds and saturates.
  logic [MCNT_W-1:0]        mul_cnt_q;
  logic                     mul_busy;
  logic [1:0]               mul_idx_q;
  logic                     mul_wb_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SW-1:0]     prod_ext, scaled;
  logic signed [31:0]       pos_sat;
  logic signed [31:0]       posx_q [2];
  logic signed [31:0]       posy_q [2];

  assign mul_busy = (mul_cnt_q != MCNT_W'(NUM_OPND));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_cnt_q <= MCNT_W'(NUM_OPND);
      mul_wb_q  <= 1'b0;
    end else if (cmd_i.start) begin
      mul_cnt_q <= '0;
      mul_wb_q  <= 1'b0;
    end else begin
      mul_wb_q <= mul_busy;
      if (mul_busy) mul_cnt_q <= mul_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_busy) begin
      prod_q    <= opnd_q[mul_cnt_q[1:0]] * $signed({1'b0, scale_q});
      mul_idx_q <= mul_cnt_q[1:0];
    end
  end

  // Align to 8 fraction bits, rounding halves upward, then clamp to 32 bits.
  always_comb begin
    prod_ext = SW'(prod_q);
    scaled   = ((prod_ext + HALF) >>> RSH) <<< LSH;
    if (scaled[SW-1:31] != {(SW - 31){scaled[31]}}) begin
      pos_sat = scaled[SW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      pos_sat = scaled[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_wb_q) begin
      if (!mul_idx_q[1]) begin
        posx_q[mul_idx_q[0]] <= pos_sat;
      end else begin
        posy_q[mul_idx_q[0]] <= pos_sat;
      end
    end
  end

  // Four texture dividers: u right, u left, v bottom, v top.
  logic [12:0]        div_texel [NUM_DIV];
  logic [12:0]        div_size  [NUM_DIV];
  logic [15:0]        div_quot  [NUM_DIV];
  logic [NUM_DIV-1:0] div_busy;

  always_comb begin
    div_texel[0] = 13'(rd_q.ax) + 13'(rd_q.gw);
    div_texel[1] = 13'(rd_q.ax);
    div_texel[2] = 13'(rd_q.ay) + 13'(rd_q.gh);
    div_texel[3] = 13'(rd_q.ay);
    div_size[0]  = aw_q;
    div_size[1]  = aw_q;
    div_size[2]  = ah_q;
    div_size[3]  = ah_q;
  end

  for (genvar g = 0; g < NUM_DIV; g++) begin : g_div
    glq_div u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (cmd_i.start),
      .texel_i (div_texel[g]),
      .size_i  (div_size[g]),
      .busy_o  (div_busy[g]),
      .quot_o  (div_quot[g])
    );
  end

  // Vertex counter and output register.
  logic [1:0] vtx_q;
  logic       out_vld_q;
  glq_vtx_t   out_q;
  logic       x_left, y_top, u_left, v_top;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vtx_q     <= CORNER_BR;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        vtx_q <= CORNER_BR;
      end else if (cmd_i.emit) begin
        vtx_q <= vtx_q + 1'b1;
      end
      if (cmd_i.emit) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Right edge on the first two corners, bottom edge on the first and last.
  always_comb begin
    x_left = vtx_q[1];
    y_top  = vtx_q[1] ^ vtx_q[0];
    u_left = x_left;
    v_top  = y_top;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.corner       <= vtx_q;
      out_q.pos_x        <= posx_q[x_left];
      out_q.pos_y        <= posy_q[y_top];
      out_q.tex_u        <= u_left ? div_quot[1] : div_quot[0];
      out_q.tex_v        <= v_top ? div_quot[3] : div_quot[2];
      out_q.vertex_color <= color_q;
      out_q.vertex_slot  <= slot_q;
      out_q.last_vertex  <= (vtx_q == CORNER_BL);
    end
  end

  assign out_valid_o = out_vld_q;
  assign vtx_o       = out_q;

  // Status back to the controller.
  always_comb begin
    sts_o.clr_last  = (clr_cnt_q == IDX_W'(NUM_GLYPHS - 1));
    sts_o.draw_go   = (req_i.req_type == REQ_DRAW) && (req_i.first_of_string || !halted_q);
    sts_o.hit       = rd_q.vld && code_ok_q;
    sts_o.calc_done = (div_busy == '0) && !mul_busy && !mul_wb_q;
    sts_o.out_free  = !out_vld_q || out_ready_i;
    sts_o.last_vtx  = (vtx_q == CORNER_BL);
  end

endmodule

// ===== hw/rtl/glyph_quad_layout_core.sv =====
// Glyph quad layout: one draw request becomes four textured quad vertices.
// A load request writes its table entry when accepted. A draw request passes
// through lookup and the 16-step bit-serial texture dividers, and no request
// is accepted until its last vertex is emitted. A halted draw is dropped and
// a missing glyph halts the string. After reset the glyph table is cleared
// one entry a cycle, during which no request is accepted.
module glyph_quad_layout_core #(
  parameter int NUM_GLYPHS = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  glq_req_if.sink                        req,
  glq_vtx_if.source                      vtx,
  input  logic                           cfg_we_i,
  input  logic [glq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [glq_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import glq_pkg::*;

  glq_cmd_t cmd;
  glq_sts_t sts;
  glq_req_t req_item;
  glq_vtx_t vtx_item;
  logic     in_ready;
  logic     out_valid;

  // Gather the request fields into one bundle for the datapath.
  always_comb begin
    req_item.req_type        = req.req_type;
    req_item.char_code       = req.char_code;
    req_item.atlas_x         = req.atlas_x;
    req_item.atlas_y         = req.atlas_y;
    req_item.glyph_width     = req.glyph_width;
    req_item.glyph_height    = req.glyph_height;
    req_item.x_offset        = req.x_offset;
    req_item.y_offset        = req.y_offset;
    req_item.x_advance       = req.x_advance;
    req_item.first_of_string = req.first_of_string;
  end

  assign req.ready = in_ready;

  glq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  glq_dpath #(
    .NUM_GLYPHS (NUM_GLYPHS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_i       (req_item),
    .out_ready_i (vtx.ready),
    .out_valid_o (out_valid),
    .vtx_o       (vtx_item),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Drive the vertex channel from the output register.
  always_comb begin
    vtx.valid        = out_valid;
    vtx.corner       = vtx_item.corner;
    vtx.pos_x        = vtx_item.pos_x;
    vtx.pos_y        = vtx_item.pos_y;
    vtx.tex_u        = vtx_item.tex_u;
    vtx.tex_v        = vtx_item.tex_v;
    vtx.vertex_color = vtx_item.vertex_color;
    vtx.vertex_slot  = vtx_item.vertex_slot;
    vtx.last_vertex  = vtx_item.last_vertex;
  end

endmodule

// ===== hw/rtl/glq_checker.sv =====
// Port-level assertions for the glyph quad layout block, bound to the top level.
module glq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  corner_i,
  input logic [31:0] pos_x_i,
  input logic [15:0] tex_u_i,
  input logic        last_vertex_i
);
  import glq_pkg::*;

  // The last-vertex flag marks exactly the bottom-left corner.
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (last_vertex_i == (corner_i == CORNER_BL)))
    else $error("last_vertex does not match corner");

  // No new request is taken while a quad is only partly delivered.
  a_busy_quad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (corner_i != CORNER_BL)) |-> !in_ready_i)
    else $error("request accepted in the middle of a quad");

  // A delivered corner other than the last is followed at once by the next corner.
  a_corner_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && (corner_i != CORNER_BL)) |=>
      (out_valid_i && (corner_i == $past(corner_i) + 2'd1)))
    else $error("corner sequence broken");

  // A stalled vertex holds its payload.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(corner_i) && $stable(pos_x_i) && $stable(tex_u_i)))
    else $error("stalled vertex changed");

endmodule

bind glyph_quad_layout_core glq_checker u_glq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (req.ready),
  .out_valid_i   (vtx.valid),
  .out_ready_i   (vtx.ready),
  .corner_i      (vtx.corner),
  .pos_x_i       (vtx.pos_x),
  .tex_u_i       (vtx.tex_u),
  .last_vertex_i (vtx.last_vertex)
);
